// ===== hw/rtl/lmbsd_pkg.sv =====
// Shared types, constants and helper functions for the LED matrix scan driver.
// Used by the top level, front end and back end in hw/rtl; depends on nothing else.
`default_nettype none

package lmbsd_pkg;

    // Default panel geometry and color depth.
    localparam int PANEL_COLS_DEF = 64;
    localparam int PANEL_ROWS_DEF = 32;
    localparam int BIT_PLANES_DEF = 3;

    // Fixed field widths.
    localparam int REQ_W     = 2;
    localparam int POS_X_W   = 7;
    localparam int POS_Y_W   = 6;
    localparam int LEVEL_W   = 8;
    localparam int PCT_W     = 7;
    localparam int BASE_W    = 16;
    localparam int OE_W      = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_TICKS = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [PCT_W-1:0]  BRIGHTNESS_RST = 7'd50;
    localparam logic [BASE_W-1:0] BASE_TICKS_RST = 16'd30;

    // Brightness scaling: duty = min(pct, 100) * 63 / 100.
    localparam int OE_FULL  = 63;
    localparam int PCT_FULL = 100;
    // ceil(2^17 / 100); exact for every product up to 63 * 100.
    localparam int OE_RECIP = 1311;
    localparam int OE_SHIFT = 17;
    localparam int OE_PROD_W = 24;

    // Color bit positions inside one plane of a stored pixel.
    localparam int BIT_RED   = 0;
    localparam int BIT_GREEN = 1;
    localparam int BIT_BLUE  = 2;
    localparam int COLOR_W   = 3;

    // Depth of the queue that holds finished results.
    localparam int RES_DEPTH = 4;
    // Depth of the queue between the front and the back.
    localparam int CMD_DEPTH = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_FLIP  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_TICK  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        PH_SHIFT = 2'd0,
        PH_LATCH = 2'd1,
        PH_SHOW  = 2'd2
    } phase_t;

    typedef enum logic {
        MODE_INIT = 1'b0,
        MODE_RUN  = 1'b1
    } back_mode_t;

    typedef struct packed {
        logic              upper_red;
        logic              upper_green;
        logic              upper_blue;
        logic              lower_red;
        logic              lower_green;
        logic              lower_blue;
        logic [2:0]        row_addr;
        logic              shift_pulse;
        logic              latch_pulse;
        logic [OE_W-1:0]   oe_duty;
        logic [1:0]        plane_index;
    } result_t;

    // Output enable duty for a brightness percentage, by reciprocal multiply.
    function automatic logic [OE_W-1:0] oe_of_pct(input logic [PCT_W-1:0] pct);
        logic [PCT_W-1:0]     clamped;
        logic [OE_PROD_W-1:0] prod;
        clamped = (pct > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : pct;
        prod    = OE_PROD_W'(clamped) * OE_PROD_W'(OE_FULL * OE_RECIP);
        return prod[OE_SHIFT +: OE_W];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/led_matrix_bcm_scan_driver.sv =====
// Top level of the LED matrix binary code modulation scan driver.
// Depends on lmbsd_pkg, lmbsd_front, lmbsd_fifo and lmbsd_back.
`default_nettype none

// Channel      | Handshake            | Payload
// -------------+----------------------+------------------------------------------
// request in   | push / full          | req_type, pos_x, pos_y, *_level
// result out   | pop / empty          | upper_*, lower_*, row_addr, shift_pulse,
//              |                      | latch_pulse, oe_duty, plane_index
// config write | cfg_write            | cfg_addr, cfg_data
//
// The back end can pop a new request while a tick's result is still in
// flight; a tick goes through the command queue, the registered memory read
// and the result queue. After reset the back end zeroes all 2 *
// 2^clog2(PANEL_COLS*PANEL_ROWS) entries of the pixel memory (4096 at the
// default size), one entry per cycle; full stays high meanwhile. Ticks stall only when the result queue is out of room.

module led_matrix_bcm_scan_driver #(
    parameter int PANEL_COLS = lmbsd_pkg::PANEL_COLS_DEF,
    parameter int PANEL_ROWS = lmbsd_pkg::PANEL_ROWS_DEF,
    parameter int BIT_PLANES = lmbsd_pkg::BIT_PLANES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration write port.
    input  wire logic                              cfg_write,
    input  wire logic [lmbsd_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [lmbsd_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Request side.
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [lmbsd_pkg::REQ_W-1:0]       req_type,
    input  wire logic [lmbsd_pkg::POS_X_W-1:0]     pos_x,
    input  wire logic [lmbsd_pkg::POS_Y_W-1:0]     pos_y,
    input  wire logic [lmbsd_pkg::LEVEL_W-1:0]     red_level,
    input  wire logic [lmbsd_pkg::LEVEL_W-1:0]     green_level,
    input  wire logic [lmbsd_pkg::LEVEL_W-1:0]     blue_level,
    // Result side.
    output logic                                   empty,
    input  wire logic                              pop,
    output logic                                   upper_red,
    output logic                                   upper_green,
    output logic                                   upper_blue,
    output logic                                   lower_red,
    output logic                                   lower_green,
    output logic                                   lower_blue,
    output logic [2:0]                             row_addr,
    output logic                                   shift_pulse,
    output logic                                   latch_pulse,
    output logic [lmbsd_pkg::OE_W-1:0]             oe_duty,
    output logic [1:0]                             plane_index
);

    // Width of one queued command: request kind, bank entry and packed pixel.
    localparam int CMD_W = lmbsd_pkg::REQ_W + $clog2(PANEL_COLS * PANEL_ROWS)
                           + lmbsd_pkg::COLOR_W * BIT_PLANES;
    localparam int RES_W  = $bits(lmbsd_pkg::result_t);
    localparam int RCNT_W = $clog2(lmbsd_pkg::RES_DEPTH + 1);
    localparam int CCNT_W = $clog2(lmbsd_pkg::CMD_DEPTH + 1);

    logic               back_ready;
    logic               cmd_push;
    logic               cmd_full;
    logic               cmd_pop;
    logic               cmd_empty;
    logic [CMD_W-1:0]   cmd_in;
    logic [CMD_W-1:0]   cmd_out;
    logic [CCNT_W-1:0]  cmd_count;
    logic               res_push;
    logic               res_full;
    logic [RCNT_W-1:0]  res_count;
    lmbsd_pkg::result_t res_in;
    lmbsd_pkg::result_t res_out;
    logic [RES_W-1:0]   res_out_bits;

    // The front end classifies each request transaction and drops pixel
    // writes that fall outside the panel before they reach the queue.
    lmbsd_front #(
        .PANEL_COLS (PANEL_COLS),
        .PANEL_ROWS (PANEL_ROWS),
        .BIT_PLANES (BIT_PLANES)
    ) u_front (
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .back_ready  (back_ready),
        .cmd_full    (cmd_full),
        .cmd_push    (cmd_push),
        .cmd_word    (cmd_in)
    );

    // Short command queue that lets the front and back stall independently.
    lmbsd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (lmbsd_pkg::CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty),
        .count   (cmd_count)
    );

    // The back end owns the pixel memory and the scan sequencer. It holds
    // off ticks until the result queue has room for their results.
    lmbsd_back #(
        .PANEL_COLS (PANEL_COLS),
        .PANEL_ROWS (PANEL_ROWS),
        .BIT_PLANES (BIT_PLANES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .back_ready (back_ready),
        .cmd_empty  (cmd_empty || (cmd_count == '0)),
        .cmd_word   (cmd_out),
        .cmd_pop    (cmd_pop),
        .res_count  (res_count),
        .res_push   (res_push),
        .res_data   (res_in)
    );

    // Result queue: a finished result waits here while new requests go on.
    lmbsd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (lmbsd_pkg::RES_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_out_bits),
        .empty   (empty),
        .count   (res_count)
    );

    assign res_out = lmbsd_pkg::result_t'(res_out_bits);

    assign upper_red   = res_out.upper_red;
    assign upper_green = res_out.upper_green;
    assign upper_blue  = res_out.upper_blue;
    assign lower_red   = res_out.lower_red;
    assign lower_green = res_out.lower_green;
    assign lower_blue  = res_out.lower_blue;
    assign row_addr    = res_out.row_addr;
    assign shift_pulse = res_out.shift_pulse;
    assign latch_pulse = res_out.latch_pulse;
    assign oe_duty     = res_out.oe_duty;
    assign plane_index = res_out.plane_index;

`ifndef ASSERT_OFF
    // The back end reserves room before it starts a tick, so the result
    // queue is never pushed while full.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    // No request is taken while the memory is still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        !back_ready |-> full)
        else $error("request accepted during clearing pass");

    // Nothing reaches the command queue before the clearing pass is done.
    assert property (@(posedge clk) disable iff (!rst_n)
        !back_ready |-> (cmd_count == '0))
        else $error("command queued during clearing pass");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lmbsd_fifo.sv =====
// Small first-in first-out queue built from registers.
// Generic payload; uses no package items.
`default_nettype none

module lmbsd_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    input  wire logic [WIDTH-1:0]                 wr_data,
    output logic                                  full,
    input  wire logic                             pop,
    output logic [WIDTH-1:0]                      rd_data,
    output logic                                  empty,
    output logic [$clog2(DEPTH+1)-1:0]            count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lmbsd_front.sv =====
// Front end: accepts requests, drops out-of-range pixel writes, quantizes
// colors and forms the bank entry index. Depends on lmbsd_pkg.
`default_nettype none

module lmbsd_front #(
    parameter int PANEL_COLS = lmbsd_pkg::PANEL_COLS_DEF,
    parameter int PANEL_ROWS = lmbsd_pkg::PANEL_ROWS_DEF,
    parameter int BIT_PLANES = lmbsd_pkg::BIT_PLANES_DEF
) (
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic [lmbsd_pkg::REQ_W-1:0]           req_type,
    input  wire logic [lmbsd_pkg::POS_X_W-1:0]         pos_x,
    input  wire logic [lmbsd_pkg::POS_Y_W-1:0]         pos_y,
    input  wire logic [lmbsd_pkg::LEVEL_W-1:0]         red_level,
    input  wire logic [lmbsd_pkg::LEVEL_W-1:0]         green_level,
    input  wire logic [lmbsd_pkg::LEVEL_W-1:0]         blue_level,
    input  wire logic                                  back_ready,
    input  wire logic                                  cmd_full,
    output logic                                       cmd_push,
    output logic [lmbsd_pkg::REQ_W + $clog2(PANEL_COLS * PANEL_ROWS)
                  + 3 * BIT_PLANES - 1:0]              cmd_word
);

    localparam int BANK_AW = $clog2(PANEL_COLS * PANEL_ROWS);
    localparam int PIX_W   = lmbsd_pkg::COLOR_W * BIT_PLANES;
    localparam int X_W     = $clog2(PANEL_COLS);
    localparam int Y_W     = $clog2(PANEL_ROWS);
    localparam int TOP     = lmbsd_pkg::LEVEL_W - BIT_PLANES;
    localparam logic [BANK_AW-1:0] COLS_ENTRY = BANK_AW'(PANEL_COLS);

    lmbsd_pkg::req_t    kind;
    logic               in_range;
    logic [X_W-1:0]     x_pos;
    logic [Y_W-1:0]     y_pos;
    logic [BANK_AW-1:0] entry;
    logic [PIX_W-1:0]   pixel;
    logic               accept;

    assign kind     = lmbsd_pkg::req_t'(req_type);
    assign full     = cmd_full || !back_ready;
    assign accept   = push && !full;
    assign in_range = (pos_x < PANEL_COLS) && (pos_y < PANEL_ROWS);
    assign x_pos    = X_W'(pos_x);
    assign y_pos    = Y_W'(pos_y);
    assign entry    = BANK_AW'(y_pos) * COLS_ENTRY + BANK_AW'(x_pos);

    // Plane p of the pixel holds bit p of each color's top BIT_PLANES bits.
    always_comb
    begin
        pixel = '0;
        for (int p = 0; p < BIT_PLANES; p++)
        begin
            pixel[lmbsd_pkg::COLOR_W * p + lmbsd_pkg::BIT_RED]   = red_level[TOP + p];
            pixel[lmbsd_pkg::COLOR_W * p + lmbsd_pkg::BIT_GREEN] = green_level[TOP + p];
            pixel[lmbsd_pkg::COLOR_W * p + lmbsd_pkg::BIT_BLUE]  = blue_level[TOP + p];
        end
    end

    always_comb
    begin
        unique case (kind)
            lmbsd_pkg::REQ_WRITE: cmd_push = accept && in_range;
            lmbsd_pkg::REQ_FLIP,
            lmbsd_pkg::REQ_CLEAR,
            lmbsd_pkg::REQ_TICK:  cmd_push = accept;
            default:              cmd_push = 1'b0;
        endcase
    end

    assign cmd_word = {kind, entry, pixel};

endmodule

`default_nettype wire

// ===== hw/rtl/lmbsd_back.sv =====
// Back end: pixel memory with both banks, clearing pass after reset, clear
// stepping, bank flip and the scan sequencer. Depends on lmbsd_pkg.
`default_nettype none

module lmbsd_back #(
    parameter int PANEL_COLS = lmbsd_pkg::PANEL_COLS_DEF,
    parameter int PANEL_ROWS = lmbsd_pkg::PANEL_ROWS_DEF,
    parameter int BIT_PLANES = lmbsd_pkg::BIT_PLANES_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [lmbsd_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  wire logic [lmbsd_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                       back_ready,
    input  wire logic                                  cmd_empty,
    input  wire logic [lmbsd_pkg::REQ_W + $clog2(PANEL_COLS * PANEL_ROWS)
                       + 3 * BIT_PLANES - 1:0]         cmd_word,
    output logic                                       cmd_pop,
    input  wire logic [$clog2(lmbsd_pkg::RES_DEPTH+1)-1:0] res_count,
    output logic                                       res_push,
    output lmbsd_pkg::result_t                         res_data
);

    localparam int BANK      = PANEL_COLS * PANEL_ROWS;
    localparam int BANK_AW   = $clog2(BANK);
    localparam int MEM_AW    = BANK_AW + 1;
    localparam int MEM_DEPTH = 2 ** MEM_AW;
    localparam int PIX_W     = lmbsd_pkg::COLOR_W * BIT_PLANES;
    localparam int X_W       = $clog2(PANEL_COLS);
    localparam int Y_W       = $clog2(PANEL_ROWS);
    localparam int ROW_GROUP = PANEL_ROWS / 4;
    localparam int ROW_W     = (ROW_GROUP > 1) ? $clog2(ROW_GROUP) : 1;
    localparam int PLANE_W   = (BIT_PLANES > 1) ? $clog2(BIT_PLANES) : 1;
    localparam int SHIFT_LEN = 2 * PANEL_COLS;
    localparam int COL_W     = $clog2(SHIFT_LEN);
    localparam int DISP_W    = lmbsd_pkg::BASE_W + BIT_PLANES;
    localparam int RCNT_W    = $clog2(lmbsd_pkg::RES_DEPTH + 1);
    localparam logic [BANK_AW-1:0] COLS_ENTRY = BANK_AW'(PANEL_COLS);

    // Command fields.
    lmbsd_pkg::req_t    cmd_kind;
    logic [BANK_AW-1:0] cmd_entry;
    logic [PIX_W-1:0]   cmd_pixel;

    // Mode and clearing pass.
    lmbsd_pkg::back_mode_t mode_reg;
    lmbsd_pkg::back_mode_t mode_next;
    logic [MEM_AW-1:0]     init_addr_reg;
    logic [MEM_AW-1:0]     init_addr_next;

    // Configuration.
    logic [lmbsd_pkg::OE_W-1:0]   oe_level_reg;
    logic [lmbsd_pkg::BASE_W-1:0] base_reg;

    // Bank and clear state.
    logic               front_bank_reg;
    logic               front_bank_next;
    logic [BANK_AW-1:0] clear_idx_reg;
    logic [BANK_AW-1:0] clear_idx_next;

    // Scan state.
    lmbsd_pkg::phase_t  phase_reg;
    lmbsd_pkg::phase_t  phase_next;
    logic [PLANE_W-1:0] plane_reg;
    logic [PLANE_W-1:0] plane_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [DISP_W-1:0]  disp_reg;
    logic [DISP_W-1:0]  disp_next;
    logic [DISP_W-1:0]  disp_inc;
    logic [DISP_W-1:0]  disp_len;

    // Shift addressing.
    logic               half;
    logic [X_W-1:0]     lx;
    logic [Y_W-1:0]     y_upper;
    logic [Y_W-1:0]     y_lower;

    // Memory ports.
    logic [PIX_W-1:0]   mem [MEM_DEPTH];
    logic               wr_en;
    logic [MEM_AW-1:0]  wr_addr;
    logic [PIX_W-1:0]   wr_data;
    logic [MEM_AW-1:0]  rd_a_addr;
    logic [MEM_AW-1:0]  rd_b_addr;
    logic [PIX_W-1:0]   rd_a_reg;
    logic [PIX_W-1:0]   rd_b_reg;

    // Result stage.
    logic               credit_ok;
    logic               tick_go;
    logic               s2_valid_reg;
    lmbsd_pkg::result_t s2_res_reg;
    lmbsd_pkg::result_t s2_res_next;
    logic [PLANE_W-1:0] s2_plane_reg;
    logic [lmbsd_pkg::COLOR_W-1:0] up_bits;
    logic [lmbsd_pkg::COLOR_W-1:0] lo_bits;

    assign {cmd_kind, cmd_entry, cmd_pixel} = cmd_word;

    assign back_ready = (mode_reg == lmbsd_pkg::MODE_RUN);
    assign credit_ok  = (RCNT_W'(res_count) + RCNT_W'(s2_valid_reg))
                        < RCNT_W'(lmbsd_pkg::RES_DEPTH);
    assign cmd_pop    = back_ready && !cmd_empty
                        && ((cmd_kind != lmbsd_pkg::REQ_TICK) || credit_ok);
    assign tick_go    = cmd_pop && (cmd_kind == lmbsd_pkg::REQ_TICK);

    // Clearing pass state machine.
    always_comb
    begin
        mode_next      = mode_reg;
        init_addr_next = init_addr_reg;
        unique case (mode_reg)
            lmbsd_pkg::MODE_INIT:
            begin
                init_addr_next = init_addr_reg + 1'b1;
                if (&init_addr_reg)
                begin
                    mode_next = lmbsd_pkg::MODE_RUN;
                end
            end
            lmbsd_pkg::MODE_RUN:
            begin
                init_addr_next = init_addr_reg;
            end
            default:
            begin
                mode_next = lmbsd_pkg::MODE_INIT;
            end
        endcase
    end

    // Write port: clearing pass, pixel writes and clear steps share it.
    always_comb
    begin
        wr_en           = 1'b0;
        wr_addr         = init_addr_reg;
        wr_data         = '0;
        front_bank_next = front_bank_reg;
        clear_idx_next  = clear_idx_reg;
        if (mode_reg == lmbsd_pkg::MODE_INIT)
        begin
            wr_en = 1'b1;
        end
        else if (cmd_pop)
        begin
            unique case (cmd_kind)
                lmbsd_pkg::REQ_WRITE:
                begin
                    wr_en   = 1'b1;
                    wr_addr = {~front_bank_reg, cmd_entry};
                    wr_data = cmd_pixel;
                end
                lmbsd_pkg::REQ_FLIP:
                begin
                    front_bank_next = ~front_bank_reg;
                end
                lmbsd_pkg::REQ_CLEAR:
                begin
                    wr_en          = 1'b1;
                    wr_addr        = {~front_bank_reg, clear_idx_reg};
                    clear_idx_next = (clear_idx_reg == BANK_AW'(BANK - 1))
                                     ? '0 : clear_idx_reg + 1'b1;
                end
                lmbsd_pkg::REQ_TICK:
                begin
                    wr_en = 1'b0;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // The first half of the shift covers rows row+ROW_GROUP, the second row.
    assign half      = (col_reg >= COL_W'(PANEL_COLS));
    assign lx        = half ? X_W'(col_reg - COL_W'(PANEL_COLS)) : X_W'(col_reg);
    assign y_upper   = half ? Y_W'(row_reg) : Y_W'(row_reg) + Y_W'(ROW_GROUP);
    assign y_lower   = y_upper + Y_W'(2 * ROW_GROUP);
    assign rd_a_addr = {front_bank_reg, BANK_AW'(y_upper) * COLS_ENTRY + BANK_AW'(lx)};
    assign rd_b_addr = {front_bank_reg, BANK_AW'(y_lower) * COLS_ENTRY + BANK_AW'(lx)};

    assign disp_inc = disp_reg + 1'b1;
    assign disp_len = DISP_W'(base_reg) << plane_reg;

    // Scan sequencer.
    always_comb
    begin
        phase_next  = phase_reg;
        plane_next  = plane_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        disp_next   = disp_reg;
        s2_res_next = '0;
        s2_res_next.row_addr    = 3'(row_reg);
        s2_res_next.plane_index = 2'(plane_reg);
        if (tick_go)
        begin
            unique case (phase_reg)
                lmbsd_pkg::PH_SHIFT:
                begin
                    s2_res_next.shift_pulse = 1'b1;
                    if (col_reg == COL_W'(SHIFT_LEN - 1))
                    begin
                        col_next   = '0;
                        phase_next = lmbsd_pkg::PH_LATCH;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
                lmbsd_pkg::PH_LATCH:
                begin
                    s2_res_next.latch_pulse = 1'b1;
                    disp_next  = '0;
                    phase_next = lmbsd_pkg::PH_SHOW;
                end
                lmbsd_pkg::PH_SHOW:
                begin
                    s2_res_next.oe_duty = oe_level_reg;
                    disp_next = disp_inc;
                    if (disp_inc >= disp_len)
                    begin
                        disp_next  = '0;
                        col_next   = '0;
                        phase_next = lmbsd_pkg::PH_SHIFT;
                        if (row_reg == ROW_W'(ROW_GROUP - 1))
                        begin
                            row_next   = '0;
                            plane_next = (plane_reg == PLANE_W'(BIT_PLANES - 1))
                                         ? '0 : plane_reg + 1'b1;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = lmbsd_pkg::PH_SHIFT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= lmbsd_pkg::MODE_INIT;
            init_addr_reg  <= '0;
            oe_level_reg   <= lmbsd_pkg::oe_of_pct(lmbsd_pkg::BRIGHTNESS_RST);
            base_reg       <= lmbsd_pkg::BASE_TICKS_RST;
            front_bank_reg <= 1'b0;
            clear_idx_reg  <= '0;
            phase_reg      <= lmbsd_pkg::PH_SHIFT;
            plane_reg      <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            disp_reg       <= '0;
            s2_valid_reg   <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            init_addr_reg  <= init_addr_next;
            front_bank_reg <= front_bank_next;
            clear_idx_reg  <= clear_idx_next;
            phase_reg      <= phase_next;
            plane_reg      <= plane_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            disp_reg       <= disp_next;
            s2_valid_reg   <= tick_go;
            if (cfg_write)
            begin
                case (cfg_addr)
                    lmbsd_pkg::CFG_BRIGHTNESS:
                    begin
                        oe_level_reg <= lmbsd_pkg::oe_of_pct(
                            cfg_data[lmbsd_pkg::PCT_W-1:0]);
                    end
                    lmbsd_pkg::CFG_BASE_TICKS:
                    begin
                        // A base of zero behaves as one.
                        base_reg <= (cfg_data == '0) ? lmbsd_pkg::BASE_W'(1)
                                                     : cfg_data;
                    end
                    default:
                    begin
                        base_reg <= base_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s2_res_reg   <= s2_res_next;
        s2_plane_reg <= plane_reg;
    end

    // Pixel memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    // Select the color bits of the plane that was scanned.
    always_comb
    begin
        up_bits = '0;
        lo_bits = '0;
        for (int p = 0; p < BIT_PLANES; p++)
        begin
            if (s2_plane_reg == PLANE_W'(p))
            begin
                up_bits = rd_a_reg[lmbsd_pkg::COLOR_W * p +: lmbsd_pkg::COLOR_W];
                lo_bits = rd_b_reg[lmbsd_pkg::COLOR_W * p +: lmbsd_pkg::COLOR_W];
            end
        end
    end

    always_comb
    begin
        res_data = s2_res_reg;
        if (s2_res_reg.shift_pulse)
        begin
            res_data.upper_red   = up_bits[lmbsd_pkg::BIT_RED];
            res_data.upper_green = up_bits[lmbsd_pkg::BIT_GREEN];
            res_data.upper_blue  = up_bits[lmbsd_pkg::BIT_BLUE];
            res_data.lower_red   = lo_bits[lmbsd_pkg::BIT_RED];
            res_data.lower_green = lo_bits[lmbsd_pkg::BIT_GREEN];
            res_data.lower_blue  = lo_bits[lmbsd_pkg::BIT_BLUE];
        end
    end

    assign res_push = s2_valid_reg;

`ifndef ASSERT_OFF
    // A result leaving the read stage always finds room in the result queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (res_count < RCNT_W'(lmbsd_pkg::RES_DEPTH)))
        else $error("result queue overrun");

    // Once running, writes never touch the bank being scanned.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && mode_reg == lmbsd_pkg::MODE_RUN) |-> (wr_addr[MEM_AW-1] != front_bank_reg))
        else $error("write into front bank");

    // A latch tick always leads into the display phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tick_go && phase_reg == lmbsd_pkg::PH_LATCH) |=> (phase_reg == lmbsd_pkg::PH_SHOW))
        else $error("latch not followed by display");

    // A flip command swaps the banks.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && cmd_kind == lmbsd_pkg::REQ_FLIP) |=> (front_bank_reg != $past(front_bank_reg)))
        else $error("flip did not swap banks");
`endif

endmodule

`default_nettype wire
